// File: hdl/bmcc_pkg.sv
// Shared types and constants for the bipartite minimum class cover core.
// No dependencies; the core, bmcc_ctrl and bmcc_dpath files refer to this package by scope.
package bmcc_pkg;

  localparam int unsigned NodeW  = 14;
  localparam int unsigned CoverW = 14;
  localparam logic [CoverW-1:0] COVER_MAX = 14'h3fff;

  // Request command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Node colors
  localparam logic [1:0] COLOR_NONE  = 2'd0;
  localparam logic [1:0] COLOR_FIRST = 2'd1;

  typedef struct packed {
    logic [1:0]       command;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic              possible;
    logic [CoverW-1:0] cover_size;
    logic              edges_dropped;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_HEAD_CLR,
    OP_ADD_RD_A,
    OP_ADD_WR_A,
    OP_ADD_RD_B,
    OP_ADD_WR_B,
    OP_COLOR_CLR,
    OP_SCAN,
    OP_SCAN_CHK,
    OP_POP,
    OP_POP_U,
    OP_LOAD_U,
    OP_EDGE,
    OP_EDGE_T,
    OP_EDGE_V,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] cmd;
    logic       ptr_last;
    logic       drop;
    logic       scan_end;
    logic       color_set;
    logic       stack_empty;
    logic       edge_nil;
    logic       conflict;
    logic       out_free;
  } sts_t;

endpackage

// File: hdl/bipartite_min_class_cover_core.sv
// Top level of the bipartite minimum class cover core.
// Depends on bmcc_pkg, bmcc_ctrl, bmcc_dpath (which uses bmcc_ram).
//
// Usage:
//  - Request channel (in_valid_i / in_stall_o / in_data_i): add edge, evaluate
//    or clear. A request is taken when valid is high and stall is low; stall is
//    low only while the core is idle, so one request is in work at a time.
//  - Response channel (out_valid_o / out_stall_i / out_data_o): one response per
//    evaluate, none for add edge or clear. The response register holds while
//    the receiver stalls; the core still takes new requests meanwhile.
//  - Config: cfg_we_i writes node_count from cfg_data_i; write only while idle.
// Operation:
//  - Add edge: two head reads, two list writes; a dropped edge stops after the first read.
//  - Clear: one list head written per cycle, over all MaxNodes heads.
//  - Evaluate: clear all MaxNodes colors, then scan each start node, pop each
//    stacked node and walk each list entry it holds, then respond.
//    The color, head, edge and stack memories each have a single read port.
// Reset: the core runs a pass emptying all MaxNodes adjacency lists and
// stalls requests until it is done.
module bipartite_min_class_cover_core #(
  parameter int unsigned MaxNodes = 16384,
  parameter int unsigned MaxEdges = 131072
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bmcc_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bmcc_pkg::rsp_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [bmcc_pkg::NodeW-1:0] cfg_data_i
);

  bmcc_pkg::ctl_t ctl;
  bmcc_pkg::sts_t sts;

  // Sequence the operations
  bmcc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i(sts),
    .ctl_o(ctl)
  );

  // Hold the graph, colors and walk stack
  bmcc_dpath #(
    .MaxNodes(MaxNodes),
    .MaxEdges(MaxEdges)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .ctl_i(ctl),
    .sts_o(sts),
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_data_i
  );

endmodule

// File: hdl/bmcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bmcc_ctrl.sv
// Sequencer for the cover core: picks one datapath operation per cycle.
// Depends on bmcc_pkg (op_e, ctl_t, sts_t, command codes).
module bmcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bmcc_pkg::sts_t sts_i,
  output bmcc_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD_CLR, S_ADD_RD_A, S_ADD_WR_A, S_ADD_RD_B, S_ADD_WR_B,
    S_COLOR_CLR, S_SCAN, S_SCAN_CHK, S_POP, S_POP_U, S_LOAD_U,
    S_EDGE, S_EDGE_T, S_EDGE_V, S_DONE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEAD_CLR;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (sts_i.accept) begin
            if (sts_i.cmd == bmcc_pkg::CMD_ADD) state_q <= S_ADD_RD_A;
            else if (sts_i.cmd == bmcc_pkg::CMD_EVAL) state_q <= S_COLOR_CLR;
            else if (sts_i.cmd == bmcc_pkg::CMD_CLEAR) state_q <= S_HEAD_CLR;
          end
        end
        S_HEAD_CLR:  if (sts_i.ptr_last) state_q <= S_IDLE;
        S_ADD_RD_A:  state_q <= sts_i.drop ? S_IDLE : S_ADD_WR_A;
        S_ADD_WR_A:  state_q <= S_ADD_RD_B;
        S_ADD_RD_B:  state_q <= S_ADD_WR_B;
        S_ADD_WR_B:  state_q <= S_IDLE;
        S_COLOR_CLR: if (sts_i.ptr_last) state_q <= S_SCAN;
        S_SCAN:      state_q <= sts_i.scan_end ? S_DONE : S_SCAN_CHK;
        S_SCAN_CHK:  state_q <= sts_i.color_set ? S_SCAN : S_POP;
        S_POP:       state_q <= sts_i.stack_empty ? S_SCAN : S_POP_U;
        S_POP_U:     state_q <= S_LOAD_U;
        S_LOAD_U:    state_q <= S_EDGE;
        S_EDGE:      state_q <= sts_i.edge_nil ? S_POP : S_EDGE_T;
        S_EDGE_T:    state_q <= S_EDGE_V;
        S_EDGE_V:    state_q <= sts_i.conflict ? S_DONE : S_EDGE;
        S_DONE:      if (sts_i.out_free) state_q <= S_IDLE;
        default:     state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:      ctl_o.op = bmcc_pkg::OP_IDLE;
      S_HEAD_CLR:  ctl_o.op = bmcc_pkg::OP_HEAD_CLR;
      S_ADD_RD_A:  ctl_o.op = bmcc_pkg::OP_ADD_RD_A;
      S_ADD_WR_A:  ctl_o.op = bmcc_pkg::OP_ADD_WR_A;
      S_ADD_RD_B:  ctl_o.op = bmcc_pkg::OP_ADD_RD_B;
      S_ADD_WR_B:  ctl_o.op = bmcc_pkg::OP_ADD_WR_B;
      S_COLOR_CLR: ctl_o.op = bmcc_pkg::OP_COLOR_CLR;
      S_SCAN:      ctl_o.op = bmcc_pkg::OP_SCAN;
      S_SCAN_CHK:  ctl_o.op = bmcc_pkg::OP_SCAN_CHK;
      S_POP:       ctl_o.op = bmcc_pkg::OP_POP;
      S_POP_U:     ctl_o.op = bmcc_pkg::OP_POP_U;
      S_LOAD_U:    ctl_o.op = bmcc_pkg::OP_LOAD_U;
      S_EDGE:      ctl_o.op = bmcc_pkg::OP_EDGE;
      S_EDGE_T:    ctl_o.op = bmcc_pkg::OP_EDGE_T;
      S_EDGE_V:    ctl_o.op = bmcc_pkg::OP_EDGE_V;
      S_DONE:      ctl_o.op = bmcc_pkg::OP_DONE;
      default:     ctl_o.op = bmcc_pkg::OP_IDLE;
    endcase
  end

endmodule

// File: hdl/bmcc_dpath.sv
// Datapath of the cover core: graph, color and stack memories plus walk registers.
// Depends on bmcc_pkg and bmcc_ram.
module bmcc_dpath #(
  parameter int unsigned MaxNodes = 16384,
  parameter int unsigned MaxEdges = 131072
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmcc_pkg::ctl_t                  ctl_i,
  output bmcc_pkg::sts_t                  sts_o,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bmcc_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bmcc_pkg::rsp_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [bmcc_pkg::NodeW-1:0]      cfg_data_i
);

  localparam int unsigned NW      = $clog2(MaxNodes);
  localparam int unsigned IW      = ((NW > bmcc_pkg::NodeW) ? NW : bmcc_pkg::NodeW) + 1;
  localparam int unsigned EntryCap = 2 * MaxEdges;
  localparam int unsigned EW      = $clog2(EntryCap) + 1;
  localparam int unsigned AW      = EW - 1;
  localparam int unsigned CW      = NW + 1;
  localparam int unsigned SW      = ((CW > bmcc_pkg::CoverW) ? CW : bmcc_pkg::CoverW) + 1;
  localparam logic [EW-1:0] NIL    = EW'(EntryCap);

  bmcc_pkg::req_t              req_q;
  logic [bmcc_pkg::NodeW-1:0]  node_count_q;
  logic [IW-1:0]               ptr_q;
  logic [EW-1:0]               fill_q, e_q;
  logic                        ovf_q, ok_q;
  logic [NW-1:0]               v_q;
  logic [1:0]                  c_q;
  logic [CW-1:0]               top_q, cnt0_q, cnt1_q;
  logic [bmcc_pkg::CoverW-1:0] total_q;
  logic                        out_valid_q;
  bmcc_pkg::rsp_t              out_q;

  logic [IW-1:0]  last;
  logic [CW-1:0]  cmin;
  logic [SW-1:0]  sum;
  logic           accept, out_free;
  logic [1:0]     other;
  logic [NW-1:0]  a_idx, b_idx;

  // memory ports
  logic          head_we;
  logic [NW-1:0] head_wa, head_ra;
  logic [EW-1:0] head_wd, head_rd;
  logic             edge_we;
  logic [AW-1:0]    edge_wa, edge_ra;
  logic [NW+EW-1:0] edge_wd, edge_rd;
  logic          color_we;
  logic [NW-1:0] color_wa, color_ra;
  logic [1:0]    color_wd, color_rd;
  logic          stack_we;
  logic [NW-1:0] stack_wa, stack_ra, stack_wd, stack_rd;

  assign a_idx    = NW'(req_q.node_a);
  assign b_idx    = NW'(req_q.node_b);
  assign last     = (IW'(node_count_q) > IW'(MaxNodes - 1)) ? IW'(MaxNodes - 1)
                                                            : IW'(node_count_q);
  assign cmin     = (cnt0_q < cnt1_q) ? cnt0_q : cnt1_q;
  assign sum      = SW'(total_q) + SW'(cmin);
  assign other    = 2'd3 - c_q;
  assign accept   = in_valid_i && (ctl_i.op == bmcc_pkg::OP_IDLE);
  assign out_free = !(out_valid_q && out_stall_i);
  assign in_stall_o = (ctl_i.op != bmcc_pkg::OP_IDLE);

  always_comb begin
    sts_o.accept      = accept;
    sts_o.cmd         = in_data_i.command;
    sts_o.ptr_last    = (ptr_q == IW'(MaxNodes - 1));
    sts_o.drop        = (IW'(req_q.node_a) >= IW'(MaxNodes)) ||
                        (IW'(req_q.node_b) >= IW'(MaxNodes)) ||
                        (fill_q > EW'(EntryCap - 2));
    sts_o.scan_end    = (ptr_q > last);
    sts_o.color_set   = (color_rd != bmcc_pkg::COLOR_NONE);
    sts_o.stack_empty = (top_q == '0);
    sts_o.edge_nil    = (e_q == NIL);
    sts_o.conflict    = (color_rd == c_q);
    sts_o.out_free    = out_free;
  end

  // Memory port selection
  always_comb begin
    head_we  = 1'b0;
    head_wa  = ptr_q[NW-1:0];
    head_wd  = NIL;
    head_ra  = a_idx;
    edge_we  = 1'b0;
    edge_wa  = fill_q[AW-1:0];
    edge_wd  = {b_idx, head_rd};
    edge_ra  = e_q[AW-1:0];
    color_we = 1'b0;
    color_wa = ptr_q[NW-1:0];
    color_wd = bmcc_pkg::COLOR_NONE;
    color_ra = ptr_q[NW-1:0];
    stack_we = 1'b0;
    stack_wa = top_q[NW-1:0];
    stack_wd = v_q;
    stack_ra = NW'(top_q - CW'(1));
    unique case (ctl_i.op)
      bmcc_pkg::OP_HEAD_CLR: head_we = 1'b1;
      bmcc_pkg::OP_ADD_WR_A: begin
        head_we = 1'b1;
        head_wa = a_idx;
        head_wd = fill_q;
        edge_we = 1'b1;
      end
      bmcc_pkg::OP_ADD_RD_B: head_ra = b_idx;
      bmcc_pkg::OP_ADD_WR_B: begin
        head_we = 1'b1;
        head_wa = b_idx;
        head_wd = fill_q;
        edge_we = 1'b1;
        edge_wd = {a_idx, head_rd};
      end
      bmcc_pkg::OP_COLOR_CLR: color_we = 1'b1;
      bmcc_pkg::OP_SCAN_CHK: begin
        color_we = !sts_o.color_set;
        color_wd = bmcc_pkg::COLOR_FIRST;
        stack_we = !sts_o.color_set;
        stack_wa = '0;
        stack_wd = ptr_q[NW-1:0];
      end
      bmcc_pkg::OP_POP_U: begin
        color_ra = stack_rd;
        head_ra  = stack_rd;
      end
      bmcc_pkg::OP_EDGE_T: color_ra = edge_rd[NW+EW-1:EW];
      bmcc_pkg::OP_EDGE_V: begin
        color_we = !sts_o.conflict && (color_rd == bmcc_pkg::COLOR_NONE);
        color_wa = v_q;
        color_wd = other;
        stack_we = color_we;
      end
      default: ;
    endcase
  end

  // Walk and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= bmcc_pkg::NodeW'(1);
      ptr_q        <= '0;
      fill_q       <= '0;
      ovf_q        <= 1'b0;
      ok_q         <= 1'b1;
      top_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_data_i;
      // Raise valid with a new response, drop it once the receiver takes it
      if ((ctl_i.op == bmcc_pkg::OP_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctl_i.op)
        bmcc_pkg::OP_IDLE: if (accept) ptr_q <= '0;
        bmcc_pkg::OP_HEAD_CLR: begin
          ptr_q <= ptr_q + IW'(1);
          if (sts_o.ptr_last) begin
            fill_q <= '0;
            ovf_q  <= 1'b0;
          end
        end
        bmcc_pkg::OP_ADD_RD_A: if (sts_o.drop) ovf_q <= 1'b1;
        bmcc_pkg::OP_ADD_WR_A, bmcc_pkg::OP_ADD_WR_B: fill_q <= fill_q + EW'(1);
        bmcc_pkg::OP_COLOR_CLR: begin
          ptr_q <= sts_o.ptr_last ? IW'(1) : ptr_q + IW'(1);
          if (sts_o.ptr_last) ok_q <= 1'b1;
        end
        bmcc_pkg::OP_SCAN_CHK: begin
          if (sts_o.color_set) ptr_q <= ptr_q + IW'(1);
          else top_q <= CW'(1);
        end
        bmcc_pkg::OP_POP: begin
          if (sts_o.stack_empty) ptr_q <= ptr_q + IW'(1);
          else top_q <= top_q - CW'(1);
        end
        bmcc_pkg::OP_EDGE_V: begin
          if (sts_o.conflict) ok_q <= 1'b0;
          else if (color_rd == bmcc_pkg::COLOR_NONE) top_q <= top_q + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      bmcc_pkg::OP_IDLE: if (accept) req_q <= in_data_i;
      bmcc_pkg::OP_COLOR_CLR: total_q <= '0;
      bmcc_pkg::OP_SCAN_CHK: begin
        cnt0_q <= CW'(1);
        cnt1_q <= '0;
      end
      bmcc_pkg::OP_POP: begin
        if (sts_o.stack_empty) begin
          total_q <= (sum > SW'(bmcc_pkg::COVER_MAX)) ? bmcc_pkg::COVER_MAX
                                                      : bmcc_pkg::CoverW'(sum);
        end
      end
      bmcc_pkg::OP_LOAD_U: begin
        c_q <= color_rd;
        e_q <= head_rd;
      end
      bmcc_pkg::OP_EDGE_T: begin
        v_q <= edge_rd[NW+EW-1:EW];
        e_q <= edge_rd[EW-1:0];
      end
      bmcc_pkg::OP_EDGE_V: begin
        if (!sts_o.conflict && color_rd == bmcc_pkg::COLOR_NONE) begin
          if (other == bmcc_pkg::COLOR_FIRST) cnt0_q <= cnt0_q + CW'(1);
          else cnt1_q <= cnt1_q + CW'(1);
        end
      end
      bmcc_pkg::OP_DONE: begin
        if (out_free) begin
          out_q.possible      <= ok_q;
          out_q.cover_size    <= ok_q ? total_q : '0;
          out_q.edges_dropped <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bmcc_ram #(.Width(EW), .Depth(MaxNodes)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd)
  );

  bmcc_ram #(.Width(NW + EW), .Depth(EntryCap)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(edge_wd),
    .raddr_i(edge_ra), .rdata_o(edge_rd)
  );

  bmcc_ram #(.Width(2), .Depth(MaxNodes)) u_color (
    .clk_i, .we_i(color_we), .waddr_i(color_wa), .wdata_i(color_wd),
    .raddr_i(color_ra), .rdata_o(color_rd)
  );

  bmcc_ram #(.Width(NW), .Depth(MaxNodes)) u_stack (
    .clk_i, .we_i(stack_we), .waddr_i(stack_wa), .wdata_i(stack_wd),
    .raddr_i(stack_ra), .rdata_o(stack_rd)
  );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for bipartite_min_class_cover_core: edge loads,
// evaluations and clears, checked against a predictor held in this file.
// Depends on bmcc_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NODES = 16384;
  localparam int unsigned SLOTS = 2 * 131072;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    bit                         is_cfg;
    logic [bmcc_pkg::NodeW-1:0] cfg_val;
    bmcc_pkg::req_t             req;
  } step_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i;
  logic                       in_stall_o;
  bmcc_pkg::req_t             in_data_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  bmcc_pkg::rsp_t             out_data_o;
  logic                       cfg_we_i;
  logic [bmcc_pkg::NodeW-1:0] cfg_data_i;

  bipartite_min_class_cover_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Graph predictor: adjacency lists, colors and walk stack of our own.
  // ---------------------------------------------------------------------
  int unsigned nodes_in_use = 1;
  int unsigned head_slot [NODES];
  int unsigned slot_target [SLOTS];
  int unsigned slot_next [SLOTS];
  bit [1:0]    shade [NODES];
  int unsigned pending_nodes [NODES];
  int unsigned slots_used;
  bit          dropped_flag;

  step_t pending_steps[$];
  bmcc_pkg::rsp_t awaited_results[$];
  int unsigned fail_count = 0;

  function automatic void empty_graph();
    for (int i = 0; i < NODES; i++) head_slot[i] = SLOTS;
    slots_used = 0;
    dropped_flag = 1'b0;
  endfunction

  function automatic void link_slot(int unsigned from, int unsigned to);
    slot_target[slots_used] = to;
    slot_next[slots_used] = head_slot[from];
    head_slot[from] = slots_used;
    slots_used++;
  endfunction

  // Color one component from start; return 0 on a same-color neighbor.
  function automatic bit color_component(int unsigned start, output int unsigned n1,
                                         output int unsigned n2);
    int unsigned depth;
    int unsigned u;
    int unsigned v;
    int unsigned e;
    bit [1:0] mine;
    bit [1:0] theirs;
    depth = 0;
    shade[start] = bmcc_pkg::COLOR_FIRST;
    n1 = 1;
    n2 = 0;
    pending_nodes[depth++] = start;
    while (depth > 0) begin
      depth--;
      u = pending_nodes[depth];
      mine = shade[u];
      theirs = 2'd3 - mine;
      e = head_slot[u];
      while (e < SLOTS && e < slots_used) begin
        v = slot_target[e];
        if (v >= NODES) break;
        if (shade[v] == mine) return 1'b0;
        if (shade[v] == bmcc_pkg::COLOR_NONE) begin
          shade[v] = theirs;
          if (theirs == bmcc_pkg::COLOR_FIRST) n1++;
          else n2++;
          if (depth < NODES) pending_nodes[depth++] = v;
        end
        e = slot_next[e];
      end
    end
    return 1'b1;
  endfunction

  // Apply one accepted request; queue the response an evaluate produces.
  function automatic void apply_request(bmcc_pkg::req_t r);
    int unsigned last;
    int unsigned total;
    int unsigned n1;
    int unsigned n2;
    bit ok;
    bmcc_pkg::rsp_t rsp;
    case (r.command)
      bmcc_pkg::CMD_ADD: begin
        if (r.node_a >= NODES || r.node_b >= NODES || slots_used > SLOTS - 2) begin
          dropped_flag = 1'b1;
        end else begin
          link_slot(32'(r.node_a), 32'(r.node_b));
          link_slot(32'(r.node_b), 32'(r.node_a));
        end
      end
      bmcc_pkg::CMD_CLEAR: empty_graph();
      bmcc_pkg::CMD_EVAL: begin
        last = (nodes_in_use > NODES - 1) ? NODES - 1 : nodes_in_use;
        total = 0;
        ok = 1'b1;
        for (int i = 0; i < NODES; i++) shade[i] = bmcc_pkg::COLOR_NONE;
        for (int unsigned i = 1; i <= last && ok; i++) begin
          if (shade[i] != bmcc_pkg::COLOR_NONE) continue;
          ok = color_component(i, n1, n2);
          if (ok) begin
            total += (n1 < n2) ? n1 : n2;
            if (total > bmcc_pkg::COVER_MAX) total = 32'(bmcc_pkg::COVER_MAX);
          end
        end
        rsp.possible = ok;
        rsp.cover_size = ok ? total[bmcc_pkg::CoverW-1:0] : '0;
        rsp.edges_dropped = dropped_flag;
        awaited_results.push_back(rsp);
      end
      default: ;  // unused code: ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_request(logic [1:0] cmd, int unsigned a, int unsigned b);
    step_t s;
    s.is_cfg = 1'b0;
    s.cfg_val = '0;
    s.req.command = cmd;
    s.req.node_a = a[bmcc_pkg::NodeW-1:0];
    s.req.node_b = b[bmcc_pkg::NodeW-1:0];
    pending_steps.push_back(s);
  endfunction

  function automatic void push_node_count(int unsigned n);
    step_t s;
    s.is_cfg = 1'b1;
    s.cfg_val = n[bmcc_pkg::NodeW-1:0];
    s.req = '0;
    pending_steps.push_back(s);
  endfunction

  bit send_idles = 1'b1;
  bit recv_idles = 1'b1;

  // Flip between idling and back-to-back stretches now and then.
  function automatic int unsigned send_gap();
    if ($urandom_range(0, 40) == 0) send_idles = !send_idles;
    return send_idles ? $urandom_range(0, 5) : 0;
  endfunction

  function automatic int unsigned recv_gap();
    if ($urandom_range(0, 10) == 0) recv_idles = !recv_idles;
    return recv_idles ? $urandom_range(0, 5) : 0;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: request channel and register writes
  // ---------------------------------------------------------------------
  int unsigned gap_left;
  int unsigned settle;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      cfg_we_i <= 1'b0;
      cfg_data_i <= '0;
      gap_left <= 0;
      settle <= 0;
      empty_graph();
    end else begin : drive
      bit took;
      bit next_valid;
      bit next_we;
      took = in_valid_i && !in_stall_o;
      if (took) apply_request(in_data_i);
      // hold a stalled request as it is
      next_valid = in_valid_i && !took;
      next_we = 1'b0;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_steps.size() > 0) begin
          if (pending_steps[0].is_cfg) begin
            // write only with the core idle and every response back
            if (!took && !in_valid_i && !in_stall_o && awaited_results.size() == 0) begin
              if (settle < 8) begin
                settle <= settle + 1;
              end else begin
                next_we = 1'b1;
                cfg_data_i <= pending_steps[0].cfg_val;
                nodes_in_use = 32'(pending_steps[0].cfg_val);
                void'(pending_steps.pop_front());
                settle <= 0;
              end
            end else begin
              settle <= 0;
            end
          end else begin
            next_valid = 1'b1;
            in_data_i <= pending_steps[0].req;
            void'(pending_steps.pop_front());
            gap_left <= send_gap();
          end
        end
      end
      in_valid_i <= next_valid;
      cfg_we_i <= next_we;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: response channel, stalls and comparison
  // ---------------------------------------------------------------------
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin : watch
      int unsigned s;
      bmcc_pkg::rsp_t want;
      s = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("response with none awaited: possible=%0d cover_size=%0d dropped=%0d",
                 out_data_o.possible, out_data_o.cover_size, out_data_o.edges_dropped);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.possible !== want.possible) begin
            $error("possible: expected %0d, got %0d", want.possible, out_data_o.possible);
            fail_count++;
          end
          if (out_data_o.cover_size !== want.cover_size) begin
            $error("cover_size: expected %0d, got %0d", want.cover_size,
                   out_data_o.cover_size);
            fail_count++;
          end
          if (out_data_o.edges_dropped !== want.edges_dropped) begin
            $error("edges_dropped: expected %0d, got %0d", want.edges_dropped,
                   out_data_o.edges_dropped);
            fail_count++;
          end
        end
        s = recv_gap();
      end else if (s > 0) begin
        s--;
      end
      stall_left <= s;
      out_stall_i <= (s > 0);
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bipartite_min_class_cover_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed cases, random phases, drain
  // ---------------------------------------------------------------------
  initial begin : sequencer
    int unsigned nc;
    int unsigned span;
    int unsigned adds;
    int unsigned a;
    int unsigned b;

    // Directed: empty graph, a path, node zero and the top node, unused code.
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);
    push_request(bmcc_pkg::CMD_ADD, 1, 2);
    push_request(bmcc_pkg::CMD_ADD, 2, 3);
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);
    push_request(bmcc_pkg::CMD_ADD, 0, 16383);
    push_request(bmcc_pkg::CMD_ADD, 16383, 16382);
    push_request(2'd3, 16383, 16383);
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);
    // Largest node count: node 16382 starts a walk that reaches the top node and node zero.
    push_node_count(16383);
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);
    // Self loop makes the graph not bipartite.
    push_request(bmcc_pkg::CMD_ADD, 5, 5);
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);
    push_request(bmcc_pkg::CMD_CLEAR, 0, 0);
    // Zero node count walks nothing.
    push_node_count(0);
    push_request(bmcc_pkg::CMD_ADD, 1, 2);
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);
    // Odd cycle conflict.
    push_node_count(8);
    push_request(bmcc_pkg::CMD_ADD, 3, 4);
    push_request(bmcc_pkg::CMD_ADD, 4, 5);
    push_request(bmcc_pkg::CMD_ADD, 5, 3);
    push_request(bmcc_pkg::CMD_EVAL, 0, 0);

    // Random phases: new node count, clear, mostly bipartite edges, evaluate.
    for (int p = 0; p < 25; p++) begin
      case ($urandom_range(0, 9))
        0: nc = 0;
        1: nc = 16383;
        2: nc = $urandom_range(0, 16383);
        default: nc = $urandom_range(1, 40);
      endcase
      push_node_count(nc);
      push_request(bmcc_pkg::CMD_CLEAR, $urandom_range(0, 16383), $urandom_range(0, 16383));
      span = (nc == 0 || nc > 60) ? 40 : nc + 2;
      adds = $urandom_range(25, 45);
      for (int i = 0; i < adds; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          push_request(2'd3, $urandom_range(0, 16383), $urandom_range(0, 16383));
        end else if ($urandom_range(0, 19) == 0) begin
          push_request(bmcc_pkg::CMD_ADD, $urandom_range(0, 16383),
                       $urandom_range(0, 16383));
        end else begin
          a = $urandom_range(0, span);
          b = $urandom_range(0, span);
          // keep most edges between opposite parities
          if (((a ^ b) & 1) == 0 && $urandom_range(0, 5) != 0) b = b ^ 1;
          push_request(bmcc_pkg::CMD_ADD, a, b);
        end
        if (i == adds / 2 && $urandom_range(0, 2) == 0) begin
          push_request(bmcc_pkg::CMD_EVAL, 0, 0);
        end
      end
      push_request(bmcc_pkg::CMD_EVAL, $urandom_range(0, 16383), $urandom_range(0, 16383));
    end

    // Reset: held low, then released at a rising edge.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent, core idle, every response back.
    do @(posedge clk_i);
    while (pending_steps.size() > 0 || in_valid_i || in_stall_o ||
           awaited_results.size() > 0);
    repeat (50) @(posedge clk_i);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("bipartite_min_class_cover_core regression: pass");
    end else begin
      $display("bipartite_min_class_cover_core regression: fail");
    end
    $finish;
  end

endmodule
